// ===== design/assert_macros.svh =====
// Assertion helpers included by the top design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond at one edge implies res at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, res, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error(msg);

`endif

// ===== design/dsou_pkg.sv =====
// ----------------------------------------------------------------------------
// dsou_pkg
// Shared constants, tables, types and helpers of the double steer odometry.
// ----------------------------------------------------------------------------
package dsou_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 8;
    localparam int STEER_W  = 19;
    localparam int DRIVE_W  = 32;
    localparam int POS_W    = 40;
    localparam int HEAD_W   = 19;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_DIAMETER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN   = 8'd1;
    localparam logic [CFG_W-1:0]     WHEEL_DIAMETER_RST = 24'd13107;
    localparam logic [CFG_W-1:0]     HEADING_GAIN_RST   = 24'd65536;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint KGAIN_Q30   = 64'sd652032874;

    localparam int ATAN_ENTRIES = 24;
    localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
        64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
        64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
        64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
        64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
        64'sd1024,      64'sd512,       64'sd256,       64'sd128
    };

    localparam longint POS_MAX = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
    localparam longint POS_MIN = -(64'sd1 <<< (POS_W - 1));

    // Sequencer of one sample.
    typedef enum logic [4:0] {
        S_IDLE, S_MLF, S_MLR, S_TF, S_TFW, S_TR, S_TRW,
        S_MXF, S_MYF, S_MXR, S_MYR, S_CYR, S_SUM, S_MH, S_HADD,
        S_HT, S_HTW, S_PX1, S_PX2, S_PY1, S_PY2, S_PY3, S_PY4, S_OUT
    } t_state;

    // Phases of the trig unit.
    typedef enum logic [2:0] {
        TP_IDLE, TP_WRAP, TP_FIX, TP_PRE, TP_ITER
    } t_trig_phase;

    typedef struct packed {
        logic start;
        logic long_wrap;
    } t_trig_req;

    // Round a Q30 constant to f fraction bits.
    function automatic longint from_q30(input longint v, input int f);
        int s;
        s = 30 - f;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint atan_at(input int i, input int f);
        return from_q30(ATAN_Q30[i], f);
    endfunction

    // Clamp to the signed position range.
    function automatic logic signed [POS_W-1:0] sat_pos(input longint v);
        longint r;
        r = v;
        if (v > POS_MAX) r = POS_MAX;
        if (v < POS_MIN) r = POS_MIN;
        return POS_W'(r);
    endfunction

endpackage

// ===== design/dsou_mul.sv =====
// ----------------------------------------------------------------------------
// dsou_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dsou_mul import dsou_pkg::*; #(
    parameter int A_W = 41,
    parameter int B_W = 25
) (
    input  logic                       i_clk,
    input  logic signed [A_W-1:0]      i_a,
    input  logic signed [B_W-1:0]      i_b,
    output logic signed [A_W+B_W-1:0]  o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    // Register every product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== design/dsou_trig.sv =====
// ----------------------------------------------------------------------------
// dsou_trig
// Angle wrap to [-pi, pi) by restoring steps, then a rotation CORDIC.
// ----------------------------------------------------------------------------
module dsou_trig import dsou_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_trig_req                      i_req,
    input  logic signed [66-FRAC_BITS-1:0] i_ang,
    output logic                           o_done,
    output logic signed [FRAC_BITS+3:0]    o_ang,
    output logic signed [FRAC_BITS+2:0]    o_cos,
    output logic signed [FRAC_BITS+2:0]    o_sin
);

    localparam int WR_W  = 66 - FRAC_BITS;
    localparam int ANG_W = FRAC_BITS + 4;
    localparam int CW    = FRAC_BITS + 3;
    localparam int HK    = 61 - 2 * FRAC_BITS;
    localparam int SK    = (FRAC_BITS < 17) ? 17 - FRAC_BITS : 0;
    localparam int MAXC  = (HK > CORDIC_STEPS) ? HK : CORDIC_STEPS;
    localparam int CNT_W = $clog2(MAXC + 1);

    localparam longint PI_L   = from_q30(PI_Q30, FRAC_BITS);
    localparam longint HP_L   = from_q30(HALF_PI_Q30, FRAC_BITS);
    localparam longint K_L    = from_q30(KGAIN_Q30, FRAC_BITS);
    localparam longint P2_L   = 2 * PI_L;
    localparam longint ML_L   = P2_L <<< HK;
    localparam longint MS_L   = P2_L <<< SK;

    localparam logic signed [WR_W-1:0]  PI_W = WR_W'(PI_L);
    localparam logic signed [WR_W-1:0]  P2_W = WR_W'(P2_L);
    localparam logic signed [ANG_W-1:0] PI_A = ANG_W'(PI_L);
    localparam logic signed [ANG_W-1:0] HP_A = ANG_W'(HP_L);
    localparam logic signed [CW-1:0]    K_C  = CW'(K_L);

    t_trig_phase              r_phase, n_phase;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [WR_W-1:0]   r_rem;
    logic signed [WR_W-1:0]   r_m;
    logic signed [ANG_W-1:0]  r_z;
    logic signed [ANG_W-1:0]  r_ang;
    logic signed [CW-1:0]     r_x;
    logic signed [CW-1:0]     r_y;
    logic                     r_neg;
    logic                     r_done;

    logic signed [WR_W-1:0]   fix_v;
    logic signed [CW-1:0]     xs;
    logic signed [CW-1:0]     ys;
    logic signed [ANG_W-1:0]  atn;
    logic                     last_iter;

    assign last_iter = (r_cnt == CNT_W'(CORDIC_STEPS - 1));

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            TP_IDLE: if (i_req.start) n_phase = TP_WRAP;
            TP_WRAP: if (r_cnt == '0) n_phase = TP_FIX;
            TP_FIX:  n_phase = TP_PRE;
            TP_PRE:  n_phase = TP_ITER;
            TP_ITER: if (last_iter) n_phase = TP_IDLE;
            default: n_phase = TP_IDLE;
        endcase
    end

    // Step operands
    always_comb begin
        fix_v = ((r_rem < 0) ? (r_rem + P2_W) : r_rem) - PI_W;
        xs    = r_x >>> r_cnt;
        ys    = r_y >>> r_cnt;
        atn   = ANG_W'(atan_at(int'(r_cnt), FRAC_BITS));
    end

    // Hold phase and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= TP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == TP_ITER) && last_iter;
        end
    end

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            TP_IDLE: begin
                if (i_req.start) begin
                    r_rem <= i_ang + PI_W;
                    r_m   <= i_req.long_wrap ? WR_W'(ML_L) : WR_W'(MS_L);
                    r_cnt <= i_req.long_wrap ? CNT_W'(HK) : CNT_W'(SK);
                end
            end
            TP_WRAP: begin
                if (r_rem >= r_m) begin
                    r_rem <= r_rem - r_m;
                end else if (r_rem < 0) begin
                    r_rem <= r_rem + r_m;
                end
                r_m   <= r_m >>> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            TP_FIX: begin
                r_z <= ANG_W'(fix_v);
            end
            TP_PRE: begin
                r_ang <= r_z;
                r_x   <= K_C;
                r_y   <= '0;
                r_cnt <= '0;
                if (r_z > HP_A) begin
                    r_z   <= r_z - PI_A;
                    r_neg <= 1'b1;
                end else if (r_z < -HP_A) begin
                    r_z   <= r_z + PI_A;
                    r_neg <= 1'b1;
                end else begin
                    r_neg <= 1'b0;
                end
            end
            TP_ITER: begin
                if (r_z >= 0) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atn;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atn;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_ang  = r_ang;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ===== design/double_steer_odometry_update_top.sv =====
// ----------------------------------------------------------------------------
// double_steer_odometry_update_top
// Dead reckoning pose update from two steered drive wheels.
// ----------------------------------------------------------------------------
// One shared trig unit is run three times per sample (front and rear
// mid-step steering, then the new heading): a restoring wrap of the angle
// one bit a cycle, followed by CORDIC_STEPS rotation steps. Eleven products
// share one registered multiplier. The input stalls while a sample is in
// work; a finished pose waits in the output register while the next sample
// is taken. Configuration writes are always ready.
module double_steer_odometry_update_top import dsou_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [STEER_W-1:0]  i_steer_front_angle,
    input  logic signed [STEER_W-1:0]  i_steer_rear_angle,
    input  logic signed [DRIVE_W-1:0]  i_drive_front_angle,
    input  logic signed [DRIVE_W-1:0]  i_drive_rear_angle,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [POS_W-1:0]    o_pose_x,
    output logic signed [POS_W-1:0]    o_pose_y,
    output logic signed [HEAD_W-1:0]   o_pose_heading,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data
);

`include "assert_macros.svh"

    localparam int A_W   = 41;
    localparam int B_W   = (FRAC_BITS + 3 > 25) ? FRAC_BITS + 3 : 25;
    localparam int P_W   = A_W + B_W;
    localparam int WR_W  = 66 - FRAC_BITS;
    localparam int ANG_W = FRAC_BITS + 4;
    localparam int CW    = FRAC_BITS + 3;
    localparam int LW    = POS_W;
    localparam logic signed [ANG_W-1:0] PI_A = ANG_W'(from_q30(PI_Q30, FRAC_BITS));

    t_state                   r_state, n_state;
    logic                     r_ovalid;
    logic [CFG_W-1:0]         r_diam;
    logic [CFG_W-1:0]         r_gain;
    logic signed [STEER_W-1:0] r_prev_sf, r_prev_sr;
    logic signed [DRIVE_W-1:0] r_prev_df, r_prev_dr;
    logic signed [POS_W-1:0]  r_pos_x, r_pos_y;
    logic signed [ANG_W-1:0]  r_heading;

    logic signed [DRIVE_W-1:0] r_ddf, r_ddr;
    logic signed [STEER_W-1:0] r_mf, r_mr;
    logic signed [LW-1:0]     r_lf, r_lr;
    logic signed [CW-1:0]     r_cf, r_sf, r_cr, r_sr, r_ch, r_sh;
    logic signed [LW-1:0]     r_dxf, r_dyf, r_dxr, r_dyr, r_dx, r_dy, r_diff;
    logic signed [WR_W-1:0]   r_hsum;
    logic signed [P_W:0]      r_acc;
    logic signed [POS_W-1:0]  r_out_x, r_out_y;
    logic signed [HEAD_W-1:0] r_out_h;

    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [P_W-1:0]    mul_p;
    t_trig_req                trig_req;
    logic signed [WR_W-1:0]   trig_ang;
    logic                     trig_done;
    logic signed [ANG_W-1:0]  trig_out_ang;
    logic signed [CW-1:0]     trig_cos, trig_sin;

    logic                     in_take;
    logic                     out_load;
    logic signed [LW:0]       dy_diff;
    logic signed [LW:0]       dx_sum, dy_sum;

    assign in_take     = i_valid && (r_state == S_IDLE);
    assign out_load    = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign dy_diff = (LW + 1)'(r_dyf) - (LW + 1)'(r_dyr);
    assign dx_sum  = (LW + 1)'(r_dxf) + (LW + 1)'(r_dxr);
    assign dy_sum  = (LW + 1)'(r_dyf) + (LW + 1)'(r_dyr);

    dsou_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    dsou_trig #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (trig_req),
        .i_ang   (trig_ang),
        .o_done  (trig_done),
        .o_ang   (trig_out_ang),
        .o_cos   (trig_cos),
        .o_sin   (trig_sin)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_take) n_state = S_MLF;
            S_MLF:  n_state = S_MLR;
            S_MLR:  n_state = S_TF;
            S_TF:   n_state = S_TFW;
            S_TFW:  if (trig_done) n_state = S_TR;
            S_TR:   n_state = S_TRW;
            S_TRW:  if (trig_done) n_state = S_MXF;
            S_MXF:  n_state = S_MYF;
            S_MYF:  n_state = S_MXR;
            S_MXR:  n_state = S_MYR;
            S_MYR:  n_state = S_CYR;
            S_CYR:  n_state = S_SUM;
            S_SUM:  n_state = S_MH;
            S_MH:   n_state = S_HADD;
            S_HADD: n_state = S_HT;
            S_HT:   n_state = S_HTW;
            S_HTW:  if (trig_done) n_state = S_PX1;
            S_PX1:  n_state = S_PX2;
            S_PX2:  n_state = S_PY1;
            S_PY1:  n_state = S_PY2;
            S_PY2:  n_state = S_PY3;
            S_PY3:  n_state = S_PY4;
            S_PY4:  n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Steer the multiplier and the trig unit
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        trig_req = '0;
        trig_ang = WR_W'(r_mf);
        unique case (r_state)
            S_MLF: begin
                mul_a = A_W'(r_ddf);
                mul_b = B_W'(signed'({1'b0, r_diam}));
            end
            S_MLR: begin
                mul_a = A_W'(r_ddr);
                mul_b = B_W'(signed'({1'b0, r_diam}));
            end
            S_TF: begin
                trig_req.start = 1'b1;
            end
            S_TR: begin
                trig_req.start = 1'b1;
                trig_ang       = WR_W'(r_mr);
            end
            S_MXF: begin
                mul_a = A_W'(r_lf);
                mul_b = B_W'(r_cf);
            end
            S_MYF: begin
                mul_a = A_W'(r_lf);
                mul_b = B_W'(r_sf);
            end
            S_MXR: begin
                mul_a = A_W'(r_lr);
                mul_b = B_W'(r_cr);
            end
            S_MYR: begin
                mul_a = A_W'(r_lr);
                mul_b = B_W'(r_sr);
            end
            S_MH: begin
                mul_a = A_W'(r_diff);
                mul_b = B_W'(signed'({1'b0, r_gain}));
            end
            S_HT: begin
                trig_req.start     = 1'b1;
                trig_req.long_wrap = 1'b1;
                trig_ang           = r_hsum;
            end
            S_PX1: begin
                mul_a = A_W'(r_dx);
                mul_b = B_W'(r_ch);
            end
            S_PX2: begin
                mul_a = A_W'(r_dy);
                mul_b = B_W'(r_sh);
            end
            S_PY1: begin
                mul_a = A_W'(r_dx);
                mul_b = B_W'(r_sh);
            end
            S_PY2: begin
                mul_a = A_W'(r_dy);
                mul_b = B_W'(r_ch);
            end
            default: ;
        endcase
    end

    // Hold state, configuration, previous sample and pose
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_diam    <= WHEEL_DIAMETER_RST;
            r_gain    <= HEADING_GAIN_RST;
            r_prev_sf <= '0;
            r_prev_sr <= '0;
            r_prev_df <= '0;
            r_prev_dr <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && (i_cfg_index == REG_WHEEL_DIAMETER)) begin
                r_diam <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == REG_HEADING_GAIN)) begin
                r_gain <= i_cfg_data;
            end
            if (in_take) begin
                r_prev_sf <= i_steer_front_angle;
                r_prev_sr <= i_steer_rear_angle;
                r_prev_df <= i_drive_front_angle;
                r_prev_dr <= i_drive_rear_angle;
            end
            if ((r_state == S_HTW) && trig_done) begin
                r_heading <= trig_out_ang;
            end
            if (r_state == S_PY2) begin
                r_pos_x <= sat_pos(64'(longint'(r_pos_x)) + 64'(r_acc >>> FRAC_BITS));
            end
            if (r_state == S_PY4) begin
                r_pos_y <= sat_pos(64'(longint'(r_pos_y)) + 64'(r_acc >>> FRAC_BITS));
            end
        end
    end

    // Advance the per-sample datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ddf <= i_drive_front_angle - r_prev_df;
            r_ddr <= i_drive_rear_angle - r_prev_dr;
            r_mf  <= STEER_W'(((STEER_W + 1)'(r_prev_sf) +
                               (STEER_W + 1)'(i_steer_front_angle)) >>> 1);
            r_mr  <= STEER_W'(((STEER_W + 1)'(r_prev_sr) +
                               (STEER_W + 1)'(i_steer_rear_angle)) >>> 1);
        end
        unique case (r_state)
            S_MLR:  r_lf <= LW'(mul_p >>> (FRAC_BITS + 1));
            S_TF:   r_lr <= LW'(mul_p >>> (FRAC_BITS + 1));
            S_TFW: begin
                if (trig_done) begin
                    r_cf <= trig_cos;
                    r_sf <= trig_sin;
                end
            end
            S_TRW: begin
                if (trig_done) begin
                    r_cr <= trig_cos;
                    r_sr <= trig_sin;
                end
            end
            S_MYF:  r_dxf <= LW'(mul_p >>> FRAC_BITS);
            S_MXR:  r_dyf <= LW'(mul_p >>> FRAC_BITS);
            S_MYR:  r_dxr <= LW'(mul_p >>> FRAC_BITS);
            S_CYR:  r_dyr <= LW'(mul_p >>> FRAC_BITS);
            S_SUM: begin
                r_diff <= sat_pos(64'(dy_diff));
                r_dx   <= LW'(dx_sum >>> 1);
                r_dy   <= LW'(dy_sum >>> 1);
            end
            S_HADD: r_hsum <= WR_W'(r_heading) + WR_W'(mul_p >>> FRAC_BITS);
            S_HTW: begin
                if (trig_done) begin
                    r_ch <= trig_cos;
                    r_sh <= trig_sin;
                end
            end
            S_PX2:  r_acc <= (P_W + 1)'(mul_p);
            S_PY1:  r_acc <= r_acc - (P_W + 1)'(mul_p);
            S_PY2:  r_acc <= (P_W + 1)'(mul_p);
            S_PY3:  r_acc <= r_acc + (P_W + 1)'(mul_p);
            default: ;
        endcase
        if (out_load) begin
            r_out_x <= r_pos_x;
            r_out_y <= r_pos_y;
            r_out_h <= r_heading[HEAD_W-1:0];
        end
    end

    assign o_valid        = r_ovalid;
    assign o_pose_x       = r_out_x;
    assign o_pose_y       = r_out_y;
    assign o_pose_heading = r_out_h;

    // A taken word starts the drive products
    `ASSERT_NEXT(a_take_starts, i_clk, i_rst_n, in_take, r_state == S_MLF, "sample not started")
    // The trig unit reports only while the sequencer waits for it
    `ASSERT_CLK(a_trig_wait, i_clk, i_rst_n,
        !trig_done || r_state == S_TFW || r_state == S_TRW || r_state == S_HTW,
        "trig result while not waiting")
    // The stored heading stays wrapped
    `ASSERT_CLK(a_head_range, i_clk, i_rst_n,
        (r_heading >= -PI_A) && (r_heading < PI_A), "heading out of range")

endmodule

// ===== bench/double_steer_odometry_update_top_test.sv =====
// ----------------------------------------------------------------------------
// double_steer_odometry_update_top_test
// Drives joint samples into the odometry block and checks every pose word.
// A scoreboard keeps its own pose, previous sample and register copies, works
// out the next pose for each accepted sample and compares the results in
// order. Several register settings are applied, with traffic gaps and stalls.
// ----------------------------------------------------------------------------
module double_steer_odometry_update_top_test;
    import dsou_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] heading;
    } t_pose;

    // Pose predictor and in-order store of expected poses.
    class odometry_scoreboard;
        longint diameter, gain;
        longint px, py, hd, last_sf, last_sr, last_df, last_dr;
        longint pi_q, half_pi_q, seed_q;
        longint atan_q [ATAN_ENTRIES];
        t_pose  pending_poses [$];
        int     errors;

        function new();
            diameter = WHEEL_DIAMETER_RST;
            gain     = HEADING_GAIN_RST;
            px = 0; py = 0; hd = 0;
            last_sf = 0; last_sr = 0; last_df = 0; last_dr = 0;
            errors = 0;
            pi_q      = round_q30(PI_Q30);
            half_pi_q = round_q30(HALF_PI_Q30);
            seed_q    = round_q30(KGAIN_Q30);
            for (int i = 0; i < ATAN_ENTRIES; i++) atan_q[i] = round_q30(ATAN_Q30[i]);
        endfunction

        function longint round_q30(longint v);
            return (v + (64'sd1 <<< (29 - FRAC_BITS_DEF))) >>> (30 - FRAC_BITS_DEF);
        endfunction

        function longint wrap_pi(longint a);
            longint r;
            r = (a + pi_q) % (2 * pi_q);
            if (r < 0) r += 2 * pi_q;
            return r - pi_q;
        endfunction

        function longint clamp_pos(longint v);
            if (v > POS_MAX) return POS_MAX;
            if (v < POS_MIN) return POS_MIN;
            return v;
        endfunction

        // Rotation-mode CORDIC with half-turn folding.
        function void cordic(input longint a, output longint c, output longint s);
            longint x, y, z, xs, ys;
            bit     flip;
            x = seed_q; y = 0; z = wrap_pi(a); flip = 0;
            if (z > half_pi_q) begin
                z -= pi_q; flip = 1;
            end else if (z < -half_pi_q) begin
                z += pi_q; flip = 1;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_ENTRIES; i++) begin
                xs = x >>> i; ys = y >>> i;
                if (z >= 0) begin
                    x -= ys; y += xs; z -= atan_q[i];
                end else begin
                    x += ys; y -= xs; z += atan_q[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint travel(longint cur, longint prev);
            logic signed [DRIVE_W-1:0] d;
            d = DRIVE_W'(cur - prev);
            return (longint'(d) * diameter) >>> (FRAC_BITS_DEF + 1);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_WHEEL_DIAMETER) diameter = data;
            else if (idx == REG_HEADING_GAIN) gain = data;
        endfunction

        // Advance the pose by one accepted sample.
        function void note_sample(longint sf, longint sr, longint df, longint dr);
            longint lf, lr, cf, snf, cr, snr, ch, sh;
            longint dxf, dyf, dxr, dyr, dx, dy, diff;
            t_pose  p;
            lf = travel(df, last_df);
            lr = travel(dr, last_dr);
            cordic((last_sf + sf) >>> 1, cf, snf);
            cordic((last_sr + sr) >>> 1, cr, snr);
            dxf = (lf * cf) >>> FRAC_BITS_DEF;
            dyf = (lf * snf) >>> FRAC_BITS_DEF;
            dxr = (lr * cr) >>> FRAC_BITS_DEF;
            dyr = (lr * snr) >>> FRAC_BITS_DEF;
            dx = (dxf + dxr) >>> 1;
            dy = (dyf + dyr) >>> 1;
            diff = clamp_pos(dyf - dyr);
            hd = wrap_pi(hd + ((diff * gain) >>> FRAC_BITS_DEF));
            cordic(hd, ch, sh);
            px = clamp_pos(px + ((dx * ch - dy * sh) >>> FRAC_BITS_DEF));
            py = clamp_pos(py + ((dx * sh + dy * ch) >>> FRAC_BITS_DEF));
            last_sf = sf; last_sr = sr; last_df = df; last_dr = dr;
            p.x = POS_W'(px); p.y = POS_W'(py); p.heading = HEAD_W'(hd);
            pending_poses.push_back(p);
        endfunction

        function void check_pose(t_pose got);
            t_pose want;
            if (pending_poses.size() == 0) begin
                $display("%0t unexpected pose x=%0d y=%0d h=%0d",
                         $time, got.x, got.y, got.heading);
                errors++;
                return;
            end
            want = pending_poses.pop_front();
            if (got.x !== want.x) begin
                $display("%0t pose_x expected %0d actual %0d", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t pose_y expected %0d actual %0d", $time, want.y, got.y);
                errors++;
            end
            if (got.heading !== want.heading) begin
                $display("%0t pose_heading expected %0d actual %0d",
                         $time, want.heading, got.heading);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      i_valid = 0;
    logic                      o_stall;
    logic signed [STEER_W-1:0] i_steer_front_angle = '0;
    logic signed [STEER_W-1:0] i_steer_rear_angle = '0;
    logic signed [DRIVE_W-1:0] i_drive_front_angle = '0;
    logic signed [DRIVE_W-1:0] i_drive_rear_angle = '0;
    logic                      o_valid;
    logic                      i_stall = 0;
    logic signed [POS_W-1:0]   o_pose_x;
    logic signed [POS_W-1:0]   o_pose_y;
    logic signed [HEAD_W-1:0]  o_pose_heading;
    logic                      i_cfg_valid = 0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_data = '0;

    odometry_scoreboard poses = new();
    int  idle_cycles = 0;
    int  burst_left = 0;
    int  stall_mode = 0;
    longint front_wheel_pos = 0, rear_wheel_pos = 0;

    double_steer_odometry_update_top dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Note accepted samples, register writes and poses.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            poses.note_sample(i_steer_front_angle, i_steer_rear_angle,
                              i_drive_front_angle, i_drive_rear_angle);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            poses.write_reg(i_cfg_index, i_cfg_data);
        if (i_rst_n && o_valid && !i_stall)
            poses.check_pose('{x: o_pose_x, y: o_pose_y, heading: o_pose_heading});
    end

    // Stall the pose output on a pattern that changes at random.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 1);
            2: i_stall <= ($urandom_range(0, 9) != 0);
            default: i_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Bail out when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[double_steer_odometry_update_top] ERROR");
            $finish;
        end
    end

    // Present one sample and hold it until taken; optional gap after each burst.
    task automatic send_sample(longint sf, longint sr, longint df, longint dr);
        int gap;
        i_valid <= 1'b1;
        i_steer_front_angle <= STEER_W'(sf);
        i_steer_rear_angle  <= STEER_W'(sr);
        i_drive_front_angle <= DRIVE_W'(df);
        i_drive_rear_angle  <= DRIVE_W'(dr);
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every pose is out and the block is quiet.
    task automatic settle();
        if (i_valid) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (poses.pending_poses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [CFG_W-1:0] diam, logic [CFG_W-1:0] gain);
        settle();
        write_reg(REG_WHEEL_DIAMETER, diam);
        write_reg(REG_HEADING_GAIN, gain);
        write_reg(REG_SPARE, CFG_W'($urandom));
    endtask

    function automatic longint steer_any();
        if ($urandom_range(0, 9) == 0) return longint'(STEER_W'($signed($urandom)));
        return longint'($urandom_range(0, 411774)) - 205887;
    endfunction

    function automatic longint drive_step(longint pos);
        case ($urandom_range(0, 9))
            0: return longint'($signed($urandom));
            1: return pos + longint'($signed($urandom)) / 4;
            default: return pos + longint'($urandom_range(0, 400000)) - 200000;
        endcase
    endfunction

    task automatic random_samples(int count);
        longint sf, sr;
        for (int n = 0; n < count; n++) begin
            sf = steer_any();
            sr = steer_any();
            front_wheel_pos = longint'(DRIVE_W'(drive_step(front_wheel_pos)));
            rear_wheel_pos  = longint'(DRIVE_W'(drive_step(rear_wheel_pos)));
            send_sample(sf, sr, front_wheel_pos, rear_wheel_pos);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first sample against zero, steering extremes, counter wrap.
        send_sample(0, 0, 65536, 65536);
        send_sample(205887, -205887, 300000, 200000);
        send_sample(-205887, 205887, -300000, 400000);
        send_sample(262143, -262144, 2147483647, -2147483648);
        send_sample(-262144, 262143, -2147483648, 2147483647);
        send_sample(102943, -102943, 0, 0);
        send_sample(102943, -102943, 2147483647, -2147483647);

        // Huge wheel and gain: lateral clamp and position saturation.
        set_regs('1, '1);
        send_sample(102943, -102943, 0, 0);
        send_sample(102943, -102943, 2147483647, -2147483647);
        send_sample(102943, -102943, -2, 2);
        send_sample(0, 0, 2147483647, 2147483647);
        send_sample(0, 0, -2, -2);
        send_sample(0, 0, 2147483647, 2147483647);
        send_sample(205887, 205887, -2147483648, -2147483648);
        send_sample(-205887, -205887, 0, 0);

        // Zero wheel and gain: pose must stand still.
        set_regs('0, '0);
        send_sample(51471, -51471, 123456, -654321);
        send_sample(-51471, 51471, -2147483648, 2147483647);
        front_wheel_pos = -2147483648;
        rear_wheel_pos  = 2147483647;

        set_regs(WHEEL_DIAMETER_RST, HEADING_GAIN_RST);
        random_samples(250);
        set_regs('1, '1);
        random_samples(150);
        set_regs(CFG_W'($urandom_range(1000, 200000)), CFG_W'($urandom_range(0, 500000)));
        random_samples(250);
        set_regs(CFG_W'($urandom), CFG_W'($urandom));
        random_samples(200);
        set_regs('0, CFG_W'($urandom));
        random_samples(80);
        set_regs(13107, 65536);
        random_samples(200);

        settle();
        if (poses.errors == 0) begin
            $display("[double_steer_odometry_update_top] OK");
        end else begin
            $display("[double_steer_odometry_update_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/dsou_pkg.sv
design/dsou_mul.sv
design/dsou_trig.sv
design/double_steer_odometry_update_top.sv
bench/double_steer_odometry_update_top_test.sv
